// ===== src/rce_pkg.sv =====
package rce_pkg;

   // Fixed-point fraction bits of slope, shift, exponent, x and y; m and p use 30.
   localparam int FRAC_BITS = 16;

   // Curve kinds.
   localparam logic [1:0] KIND_LINEAR = 2'd0;
   localparam logic [1:0] KIND_POWER  = 2'd1;
   localparam logic [1:0] KIND_LOGIST = 2'd2;
   localparam logic [1:0] KIND_EXP    = 2'd3;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_KIND     = 2'd0;
   localparam logic [1:0] CSR_SLOPE    = 2'd1;
   localparam logic [1:0] CSR_SHIFT    = 2'd2;
   localparam logic [1:0] CSR_EXPONENT = 2'd3;

   localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q     = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

   // Everything one item carries down the pipeline; each stage updates some fields.
   typedef struct packed {
      logic [1:0]         kind;
      logic               neg;
      logic               zero;
      logic signed [31:0] a;
      logic [4:0]         n;
      logic [30:0]        m;
      logic [15:0]        frac;
      logic signed [31:0] t;
      logic [30:0]        p;
      logic signed [64:0] prod;
      logic signed [31:0] y;
      logic [31:0]        den;
      logic [32:0]        rem;
      logic [16:0]        quo;
   } item_type;

   // Saturate a wide signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat_q(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < 65'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // 2^(2^-idx) with 30 fraction bits, built by repeated truncating square roots.
   function automatic logic [31:0] root_q30(input int idx);
      logic [63:0] cur;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bit_v;
      cur = 64'd1 << 31;
      for (int i = 1; i <= idx; i++) begin
         v     = cur << 30;
         r     = 64'd0;
         bit_v = 64'd1 << 62;
         for (int j = 0; j < 32; j++) begin
            if (v >= r + bit_v) begin
               v = v - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
         cur = r;
      end
      return cur[31:0];
   endfunction

endpackage

// ===== src/rce_log_step.sv =====
// One bit of the base-2 logarithm: square the mantissa and renormalise.
module rce_log_step
   import rce_pkg::*;
#(
   parameter int STEP = 1
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_vld,
   input  item_type in_item,
   output logic     out_vld,
   output item_type out_item
);

   localparam int FB = FRAC_BITS - STEP;

   logic        vld_ff;
   item_type    item_ff;
   item_type    item_in;
   logic [61:0] sq;
   logic [31:0] m2;

   // Square, truncate to 30 fraction bits and fold back below 2.0.
   always_comb begin
      item_in = in_item;
      sq      = 62'(in_item.m) * 62'(in_item.m);
      m2      = sq[61:30];
      if (m2[31]) begin
         item_in.m        = m2[31:1];
         item_in.frac[FB] = 1'b1;
      end else begin
         item_in.m = m2[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_item = item_ff;

endmodule

// ===== src/rce_exp_step.sv =====
// One bit of the fractional power of two: multiply by 2^(2^-STEP) when that bit is set.
module rce_exp_step
   import rce_pkg::*;
#(
   parameter int STEP = 1
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_vld,
   input  item_type in_item,
   output logic     out_vld,
   output item_type out_item
);

   localparam int          FB   = FRAC_BITS - STEP;
   localparam logic [31:0] ROOT = root_q30(STEP);

   logic        vld_ff;
   item_type    item_ff;
   item_type    item_in;
   logic [62:0] pr;

   // Truncating Q30 product with the root constant.
   always_comb begin
      item_in = in_item;
      pr      = 63'(in_item.p) * 63'(ROOT);
      if (in_item.t[FB]) begin
         item_in.p = pr[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_item = item_ff;

endmodule

// ===== src/rce_div_step.sv =====
// One quotient bit of the restoring divider used by the logistic curve.
module rce_div_step
   import rce_pkg::*;
#(
   parameter int BIT = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_vld,
   input  item_type in_item,
   output logic     out_vld,
   output item_type out_item
);

   logic        vld_ff;
   item_type    item_ff;
   item_type    item_in;
   logic [48:0] dsh;

   // Compare the remainder with the shifted divisor and subtract when it fits.
   always_comb begin
      item_in = in_item;
      dsh     = {17'd0, in_item.den} << BIT;
      if ({16'd0, in_item.rem} >= dsh) begin
         item_in.rem      = in_item.rem - dsh[32:0];
         item_in.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_item = item_ff;

endmodule

// ===== src/response_curve_evaluator_top.sv =====
// A req beat passes stages 0-1, log2 steps, stages 2-5, exp2 steps, stages 6-8,
// divider steps and stage 9. Throughput: one sample per cycle; the pipeline moves
// as a whole and holds while the output register is full and rsp_tready is low.
// The depth is set by the 16 log2 squaring steps, 16 exp2 multiply steps and the
// 17-step divider. Reset (synchronous, active high) empties the pipeline and sets
// the registers to linear, slope 1.0, shift 0, exponent 2.0.
module response_curve_evaluator_top
   import rce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] x
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] y, [23:17] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic               adv;
   logic [1:0]         kind_ff;
   logic signed [31:0] slope_ff;
   logic signed [31:0] shift_ff;
   logic signed [31:0] expo_ff;

   item_type s0_in, s0_ff, s1_in, s1_ff, s2_in, s2_ff, s3_in, s3_ff;
   item_type s4_in, s4_ff, s5_in, s5_ff, s6_in, s6_ff, s7_in, s7_ff, s8_in, s8_ff;
   logic     s0_vld_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic     s5_vld_ff, s6_vld_ff, s7_vld_ff, s8_vld_ff, s9_vld_ff;
   logic [16:0] y_in, y_ff;

   item_type log_item [0:FRAC_BITS];
   logic     log_vld  [0:FRAC_BITS];
   item_type exp_item [0:FRAC_BITS];
   logic     exp_vld  [0:FRAC_BITS];
   item_type div_item [0:17];
   logic     div_vld  [0:17];

   assign adv        = !s9_vld_ff || rsp_tready;
   assign req_tready = adv;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_LINEAR;
         slope_ff <= ONE_Q;
         shift_ff <= 32'sd0;
         expo_ff  <= ONE_Q <<< 1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_KIND:     kind_ff  <= csr_wdata[1:0];
            CSR_SLOPE:    slope_ff <= csr_wdata;
            CSR_SHIFT:    shift_ff <= csr_wdata;
            CSR_EXPONENT: expo_ff  <= csr_wdata;
         endcase
      end
   end

   // Valid bits of the stages held in this module.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
         s9_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_tvalid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= log_vld[FRAC_BITS];
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= exp_vld[FRAC_BITS];
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
         s9_vld_ff <= div_vld[17];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
         y_ff  <= y_in;
      end
   end

   // Stage 0: saturating a = x - shift.
   always_comb begin
      s0_in      = '0;
      s0_in.kind = kind_ff;
      s0_in.a    = sat_q(65'(33'(signed'(req_tdata)) - 33'(shift_ff)));
      s0_in.neg  = s0_in.a[31];
   end

   // Stage 1: magnitude, leading one and normalised log2 mantissa.
   logic [31:0] u;
   always_comb begin
      s1_in = s0_ff;
      u     = s0_ff.neg ? 32'(-s0_ff.a) : 32'(s0_ff.a);
      s1_in.zero = (u == 32'd0);
      s1_in.n    = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (u[i]) begin
            s1_in.n = 5'(i);
         end
      end
      if (s1_in.n == 5'd31) begin
         s1_in.m = u[31:1];
      end else begin
         s1_in.m = 31'(u << (5'd30 - s1_in.n));
      end
   end

   assign log_item[0] = s1_ff;
   assign log_vld[0]  = s1_vld_ff;

   // Fraction bits of log2, one per stage.
   for (genvar g = 1; g <= FRAC_BITS; g++) begin : g_log
      rce_log_step #(.STEP(g)) u_log (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_vld   (log_vld[g - 1]),
         .in_item  (log_item[g - 1]),
         .out_vld  (log_vld[g]),
         .out_item (log_item[g])
      );
   end

   // Stage 2: first product; operands depend on the curve kind.
   logic signed [32:0] opa;
   logic signed [31:0] opb;
   logic signed [5:0]  lg_int;
   always_comb begin
      s2_in  = log_item[FRAC_BITS];
      lg_int = signed'({1'b0, s2_in.n}) - 6'sd16;
      opb    = s2_in.a;
      unique case (s2_in.kind)
         KIND_LINEAR: opa = 33'(slope_ff);
         KIND_POWER: begin
            opa = 33'(expo_ff);
            opb = {{10{lg_int[5]}}, lg_int, s2_in.frac};
         end
         KIND_LOGIST: opa = -33'(slope_ff);
         KIND_EXP:    opa = 33'(expo_ff);
      endcase
      s2_in.prod = 65'(opa) * 65'(opb);
   end

   // Stage 3: floor and saturate; this is the linear result.
   always_comb begin
      s3_in   = s2_ff;
      s3_in.t = sat_q(s2_ff.prod >>> FRAC_BITS);
      s3_in.y = s3_in.t;
   end

   // Stage 4: scale by log2(e) for the exponential kinds.
   always_comb begin
      s4_in      = s3_ff;
      s4_in.prod = 65'(s3_ff.t) * 65'(LOG2E_Q30);
   end

   // Stage 5: floor and saturate for the exponential kinds; start exp2 product at 1.0.
   always_comb begin
      s5_in   = s4_ff;
      s5_in.p = 31'd1 << 30;
      if (s4_ff.kind == KIND_LOGIST || s4_ff.kind == KIND_EXP) begin
         s5_in.t = sat_q(s4_ff.prod >>> 30);
      end
   end

   assign exp_item[0] = s5_ff;
   assign exp_vld[0]  = s5_vld_ff;

   for (genvar g = 1; g <= FRAC_BITS; g++) begin : g_exp
      rce_exp_step #(.STEP(g)) u_exp (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_vld   (exp_vld[g - 1]),
         .in_item  (exp_item[g - 1]),
         .out_vld  (exp_vld[g]),
         .out_item (exp_item[g])
      );
   end

   // Stage 6: apply the integer part of the exponent, then form the operand of the
   // last product and the divider's numerator and divisor.
   logic signed [16:0] sh;
   logic [16:0]        amt;
   logic [30:0]        ev;
   logic [30:0]        mag;
   always_comb begin
      s6_in = exp_item[FRAC_BITS];
      sh    = 17'(signed'(s6_in.t[31:FRAC_BITS])) - 17'sd14;
      amt   = 17'(-sh);
      if (sh > 17'sd0) begin
         ev = Q_MAX[30:0];
      end else if (sh == 17'sd0) begin
         ev = s6_in.p;
      end else if (amt >= 17'd31) begin
         ev = 31'd0;
      end else begin
         ev = s6_in.p >> amt[4:0];
      end
      // A zero base in the power curve depends only on the exponent's sign.
      if (s6_in.zero) begin
         if (expo_ff > 32'sd0) begin
            mag = 31'd0;
         end else if (expo_ff == 32'sd0) begin
            mag = ONE_Q[30:0];
         end else begin
            mag = Q_MAX[30:0];
         end
      end else begin
         mag = ev;
      end
      if (s6_in.kind == KIND_POWER) begin
         s6_in.t = s6_in.neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      end else begin
         s6_in.t = signed'({1'b0, ev}) - ONE_Q;
      end
      s6_in.den = {1'b0, ev} + 32'(ONE_Q);
      s6_in.rem = {1'b1, 32'd0} + 33'(s6_in.den >> 1);
      s6_in.quo = 17'd0;
   end

   // Stage 7: product with the slope.
   always_comb begin
      s7_in      = s6_ff;
      s7_in.prod = 65'(slope_ff) * 65'(s6_ff.t);
   end

   // Stage 8: floor and saturate for the power and exponential curves.
   always_comb begin
      s8_in = s7_ff;
      if (s7_ff.kind == KIND_POWER || s7_ff.kind == KIND_EXP) begin
         s8_in.y = sat_q(s7_ff.prod >>> FRAC_BITS);
      end
   end

   assign div_item[0] = s8_ff;
   assign div_vld[0]  = s8_vld_ff;

   // Rounded 2^32 / (1.0 + exp), one quotient bit per stage from the top.
   for (genvar g = 0; g < 17; g++) begin : g_div
      rce_div_step #(.BIT(16 - g)) u_div (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_vld   (div_vld[g]),
         .in_item  (div_item[g]),
         .out_vld  (div_vld[g + 1]),
         .out_item (div_item[g + 1])
      );
   end

   // Stage 9: pick the result and clamp it to [0, 1.0] in the output register.
   logic signed [31:0] yy;
   always_comb begin
      if (div_item[17].kind == KIND_LOGIST) begin
         yy = signed'({15'd0, div_item[17].quo});
      end else begin
         yy = div_item[17].y;
      end
      if (yy < 32'sd0) begin
         y_in = 17'd0;
      end else if (yy > ONE_Q) begin
         y_in = ONE_Q[16:0];
      end else begin
         y_in = yy[16:0];
      end
   end

   assign rsp_tvalid = s9_vld_ff;
   assign rsp_tdata  = {7'd0, y_ff};

endmodule
